### rtl/bp24_pkg.sv
package bp24_pkg;

    localparam int MaxWidth = 4096;
    localparam int ColW     = $clog2(MaxWidth);
    localparam int WidthW   = 13;
    localparam int ColorW   = 24;
    localparam int CfgDataW = 24;
    localparam int CfgIdxW  = 2;
    localparam int PalDepth = 256;
    localparam int PalAddrW = $clog2(PalDepth);

    localparam logic [7:0] AlphaMax = 8'hff;

    typedef enum logic [1:0] {
        MODE_PALETTE = 2'd0,
        MODE_PASS    = 2'd1,
        MODE_BLEND   = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MODE  = 2'd0,
        REG_WIDTH = 2'd1,
        REG_BG    = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_PIXEL   = 1'b0,
        CMD_PALETTE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PASS,
        KIND_PALETTE,
        KIND_BLEND
    } kind_t;

endpackage

### rtl/bp24_in_if.sv
interface bp24_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [7:0]                 data_byte;
    logic [7:0]                 table_index;
    logic [bp24_pkg::ColorW-1:0] table_color;

    modport source (output valid, command, data_byte, table_index, table_color,
                    input ready);
    modport sink   (input valid, command, data_byte, table_index, table_color,
                    output ready);
endinterface

### rtl/bp24_out_if.sv
interface bp24_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       row_end;
    logic       last;

    modport source (output valid, out_byte, row_end, last, input ready);
    modport sink   (input valid, out_byte, row_end, last, output ready);
endinterface

### rtl/bp24_cfg_if.sv
interface bp24_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bp24_pkg::CfgIdxW-1:0]  reg_index;
    logic [bp24_pkg::CfgDataW-1:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

### rtl/bp24_ram.sv
module bp24_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bitmap_pixel_to_24bit_converter_top.sv
// Bitmap pixel stream to 24-bit BGR byte stream.
// pixel_in carries one word per source byte: a pixel data byte (command 0) or a
// palette entry write (command 1, table_index/table_color). byte_out carries one
// 24bpp output byte per word, with row_end on the byte that closes a padded row
// and last on the final word caused by an input word. cfg writes pixel_mode,
// image_width and background_color; it is always ready. The user must use cfg
// only while idle; the block itself does not enforce this. An input word passes
// the capture stage (palette read or operand capture), then the output register
// that builds its output words. One output word leaves per cycle while byte_out
// is ready: an 8bpp or 32bpp pixel gives 3, a row-closing one up to 6 with pads,
// a pass-through word 1; gathered bytes, skipped pad bytes and palette writes none.
// The rate is set by the single-word output register draining its word list.
// A new input word is taken while the previous one's output words still drain.
// If byte_out stalls, the output register holds, then the capture stage fills and
// pixel_in deasserts ready; nothing is dropped. Reset clears all position state
// and loads pixel_mode 0, image_width 1, background white; palette contents are
// undefined until written.
module bitmap_pixel_to_24bit_converter_top (
    input  logic       clk,
    input  logic       rst_n,
    bp24_in_if.sink    pixel_in,
    bp24_out_if.source byte_out,
    bp24_cfg_if.sink   cfg
);

    localparam int ColW   = bp24_pkg::ColW;
    localparam int WidthW = bp24_pkg::WidthW;
    localparam int ColorW = bp24_pkg::ColorW;

    function automatic logic [7:0] blend_byte(
        input logic [7:0] a,
        input logic [7:0] bg,
        input logic [7:0] c
    );
        logic [7:0]  inv;
        logic [16:0] sum;
        logic [16:0] t;
        begin
            inv = bp24_pkg::AlphaMax - a;
            sum = ({9'd0, inv} * {9'd0, bg}) + ({9'd0, a} * {9'd0, c});
            t   = sum + {8'd0, sum[16:8]} + 17'd1;
            return t[15:8];
        end
    endfunction

    bp24_pkg::mode_t           mode_reg;
    logic [WidthW-1:0]         width_reg;
    logic [ColorW-1:0]         bg_reg;

    logic [1:0]                bip_reg, bip_next;
    logic [ColW-1:0]           col_reg, col_next;
    logic [1:0]                pad_reg, pad_next;
    logic [ColorW-1:0]         gath_reg, gath_next;

    logic                      s1_valid_reg;
    bp24_pkg::kind_t           s1_kind_reg, kind_next;
    logic [1:0]                s1_npad_reg, npad_next;
    logic                      s1_re_reg, re_next;
    logic [7:0]                s1_data_reg;
    logic [ColorW-1:0]         s1_color_reg;

    logic                      s2_valid_reg;
    logic [7:0]                s2_b0_reg, s2_b1_reg, s2_b2_reg;
    logic [2:0]                s2_cnt_reg, s2_ptr_reg;
    logic                      s2_re_reg;

    logic                      in_acc, pix_acc, s2_last, s2_done, s2_free, s1_adv;
    logic [WidthW-1:0]         w_eff;
    logic [WidthW-1:0]         col_inc;
    logic                      close;
    logic [ColorW-1:0]         pal_rdata;
    logic [7:0]                ld_b0, ld_b1, ld_b2;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bp24_pkg::MODE_PALETTE;
            width_reg <= WidthW'(1);
            bg_reg    <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (bp24_pkg::reg_idx_t'(cfg.reg_index))
                bp24_pkg::REG_MODE:  mode_reg  <= bp24_pkg::mode_t'(cfg.reg_data[1:0]);
                bp24_pkg::REG_WIDTH: width_reg <= cfg.reg_data[WidthW-1:0];
                bp24_pkg::REG_BG:    bg_reg    <= cfg.reg_data[ColorW-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WidthW'(1);
        end
        else if (width_reg > WidthW'(bp24_pkg::MaxWidth))
        begin
            w_eff = WidthW'(bp24_pkg::MaxWidth);
        end
        else
        begin
            w_eff = width_reg;
        end
    end

    assign s2_last = (s2_ptr_reg == s2_cnt_reg - 3'd1);
    assign s2_done = s2_valid_reg && byte_out.ready && s2_last;
    assign s2_free = !s2_valid_reg || s2_done;
    assign s1_adv  = s1_valid_reg && ((s1_kind_reg == bp24_pkg::KIND_NONE) || s2_free);

    assign pixel_in.ready = !s1_valid_reg || s1_adv;
    assign in_acc  = pixel_in.valid && pixel_in.ready;
    assign pix_acc = in_acc && (pixel_in.command == bp24_pkg::CMD_PIXEL);

    assign col_inc = {1'b0, col_reg} + WidthW'(1);
    assign close   = (col_inc >= w_eff);

    // work out the word plan and the next position state
    always_comb
    begin
        bip_next  = bip_reg;
        col_next  = col_reg;
        pad_next  = pad_reg;
        gath_next = gath_reg;
        kind_next = bp24_pkg::KIND_NONE;
        npad_next = 2'd0;
        re_next   = 1'b0;
        if (pix_acc)
        begin
            unique case (mode_reg)
                bp24_pkg::MODE_PALETTE:
                begin
                    if (pad_reg != 2'd0)
                    begin
                        pad_next = pad_reg - 2'd1;
                    end
                    else
                    begin
                        kind_next = bp24_pkg::KIND_PALETTE;
                        col_next  = close ? '0 : col_inc[ColW-1:0];
                        if (close)
                        begin
                            npad_next = w_eff[1:0];
                            re_next   = 1'b1;
                            pad_next  = 2'd0 - w_eff[1:0];
                        end
                    end
                end
                bp24_pkg::MODE_PASS:
                begin
                    kind_next = bp24_pkg::KIND_PASS;
                    if (pad_reg != 2'd0)
                    begin
                        pad_next = pad_reg - 2'd1;
                        re_next  = (pad_reg == 2'd1);
                    end
                    else if (bip_reg >= 2'd2)
                    begin
                        bip_next = 2'd0;
                        col_next = close ? '0 : col_inc[ColW-1:0];
                        if (close)
                        begin
                            pad_next = w_eff[1:0];
                            re_next  = (w_eff[1:0] == 2'd0);
                        end
                    end
                    else
                    begin
                        bip_next = bip_reg + 2'd1;
                    end
                end
                bp24_pkg::MODE_BLEND:
                begin
                    if (pad_reg != 2'd0)
                    begin
                        pad_next = pad_reg - 2'd1;
                    end
                    else if (bip_reg != 2'd3)
                    begin
                        gath_next[{bip_reg, 3'b000} +: 8] = pixel_in.data_byte;
                        bip_next = bip_reg + 2'd1;
                    end
                    else
                    begin
                        kind_next = bp24_pkg::KIND_BLEND;
                        bip_next  = 2'd0;
                        col_next  = close ? '0 : col_inc[ColW-1:0];
                        if (close)
                        begin
                            npad_next = w_eff[1:0];
                            re_next   = 1'b1;
                        end
                    end
                end
                default:
                begin
                    kind_next = bp24_pkg::KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bip_reg  <= 2'd0;
            col_reg  <= '0;
            pad_reg  <= 2'd0;
            gath_reg <= '0;
        end
        else
        begin
            bip_reg  <= bip_next;
            col_reg  <= col_next;
            pad_reg  <= pad_next;
            gath_reg <= gath_next;
        end
    end

    bp24_ram #(
        .WIDTH (ColorW),
        .DEPTH (bp24_pkg::PalDepth)
    ) u_palette (
        .clk   (clk),
        .we    (in_acc && (pixel_in.command == bp24_pkg::CMD_PALETTE)),
        .waddr (pixel_in.table_index),
        .wdata (pixel_in.table_color),
        .re    (pix_acc),
        .raddr (pixel_in.data_byte),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= bp24_pkg::KIND_NONE;
        end
        else if (pixel_in.ready)
        begin
            s1_valid_reg <= in_acc;
            s1_kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_npad_reg  <= npad_next;
            s1_re_reg    <= re_next;
            s1_data_reg  <= pixel_in.data_byte;
            s1_color_reg <= gath_reg;
        end
    end

    always_comb
    begin
        unique case (s1_kind_reg)
            bp24_pkg::KIND_PALETTE:
            begin
                ld_b0 = pal_rdata[7:0];
                ld_b1 = pal_rdata[15:8];
                ld_b2 = pal_rdata[23:16];
            end
            bp24_pkg::KIND_BLEND:
            begin
                ld_b0 = blend_byte(s1_data_reg, bg_reg[7:0],   s1_color_reg[7:0]);
                ld_b1 = blend_byte(s1_data_reg, bg_reg[15:8],  s1_color_reg[15:8]);
                ld_b2 = blend_byte(s1_data_reg, bg_reg[23:16], s1_color_reg[23:16]);
            end
            default:
            begin
                ld_b0 = s1_data_reg;
                ld_b1 = 8'd0;
                ld_b2 = 8'd0;
            end
        endcase
    end

    // load the word list, then advance one word per handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_ptr_reg   <= 3'd0;
            s2_cnt_reg   <= 3'd1;
        end
        else if (s1_adv && (s1_kind_reg != bp24_pkg::KIND_NONE))
        begin
            s2_valid_reg <= 1'b1;
            s2_ptr_reg   <= 3'd0;
            s2_cnt_reg   <= (s1_kind_reg == bp24_pkg::KIND_PASS) ? 3'd1
                                                                 : 3'd3 + {1'b0, s1_npad_reg};
        end
        else if (s2_done)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_valid_reg && byte_out.ready)
        begin
            s2_ptr_reg <= s2_ptr_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && (s1_kind_reg != bp24_pkg::KIND_NONE))
        begin
            s2_b0_reg <= ld_b0;
            s2_b1_reg <= ld_b1;
            s2_b2_reg <= ld_b2;
            s2_re_reg <= s1_re_reg;
        end
    end

    always_comb
    begin
        unique case (s2_ptr_reg)
            3'd0:    byte_out.out_byte = s2_b0_reg;
            3'd1:    byte_out.out_byte = s2_b1_reg;
            3'd2:    byte_out.out_byte = s2_b2_reg;
            default: byte_out.out_byte = 8'd0;
        endcase
    end

    assign byte_out.valid   = s2_valid_reg;
    assign byte_out.last    = s2_last;
    assign byte_out.row_end = s2_last && s2_re_reg;

endmodule

### dv/testbench.sv
module testbench;

    localparam int HalfPeriod   = 6;
    localparam int SettleCycles = 10;
    localparam int LimitCycles  = 200000;
    localparam int RandomTarget = 63;
    localparam int LongHold     = 90;

    localparam int WidthW   = bp24_pkg::WidthW;
    localparam int ColorW   = bp24_pkg::ColorW;
    localparam int CfgDataW = bp24_pkg::CfgDataW;
    localparam int PalDepth = bp24_pkg::PalDepth;
    localparam int MaxWidth = bp24_pkg::MaxWidth;
    localparam logic [7:0] AlphaMax = bp24_pkg::AlphaMax;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_end;
        logic       last;
    } bgr_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bp24_in_if  pixel_in ();
    bp24_out_if byte_out ();
    bp24_cfg_if cfg ();

    bitmap_pixel_to_24bit_converter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_in),
        .byte_out (byte_out),
        .cfg      (cfg)
    );

    // converter state as the checker sees it
    bp24_pkg::mode_t   cur_mode;
    logic [WidthW-1:0] row_width;
    logic [ColorW-1:0] bg_color;
    logic [1:0]        pix_pos;
    int                col_count;
    logic [1:0]        pad_left;
    logic [ColorW-1:0] bgra_gather;
    logic [ColorW-1:0] colour_table [PalDepth];
    bit                table_filled [PalDepth];
    logic [7:0]        filled_list [$];

    bgr_word_t expected_bytes [$];
    bgr_word_t step_bytes [$];

    int in_gap_max  = 0;
    int out_gap_max = 0;
    int out_gap     = 0;
    int hold_left   = 0;
    int words_sent    = 0;
    int random_items  = 0;
    int bytes_checked = 0;
    int mismatches    = 0;

    always
    begin
        #HalfPeriod clk = 1'b1;
        #HalfPeriod clk = 1'b0;
    end

    function automatic int row_pixels();
        int w;
        w = int'(row_width);
        if (w == 0)
            w = 1;
        if (w > MaxWidth)
            w = MaxWidth;
        return w;
    endfunction

    function automatic void mark_row_end();
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].row_end = 1'b1;
    endfunction

    function automatic void close_pixel(bit pass_pads);
        int w;
        int opad;
        w = row_pixels();
        col_count++;
        if (col_count < w)
            return;
        col_count = 0;
        opad = (4 - (3 * w) % 4) % 4;
        if (pass_pads)
        begin
            pad_left = opad[1:0];
            if (opad == 0)
                mark_row_end();
            return;
        end
        for (int i = 0; i < opad; i++)
            step_bytes.push_back('{8'h00, (i + 1 == opad), 1'b0});
        if (opad == 0)
            mark_row_end();
        pad_left = (cur_mode == bp24_pkg::MODE_PALETTE) ? 2'((4 - w % 4) % 4) : 2'd0;
    endfunction

    function automatic void predict_bgr_bytes(bp24_pkg::cmd_t cmd, logic [7:0] data,
                                              logic [7:0] index, logic [ColorW-1:0] colour);
        logic [ColorW-1:0] c;
        int a;
        int full;
        int mix;
        step_bytes.delete();
        full = int'(AlphaMax);
        if (cmd == bp24_pkg::CMD_PALETTE)
        begin
            colour_table[index] = colour;
            if (!table_filled[index])
            begin
                table_filled[index] = 1'b1;
                filled_list.push_back(index);
            end
            return;
        end
        if (cur_mode == bp24_pkg::MODE_UNUSED)
            return;
        if (pad_left != 0)
        begin
            pad_left--;
            if (cur_mode == bp24_pkg::MODE_PASS)
                expected_bytes.push_back('{data, (pad_left == 0), 1'b1});
            return;
        end
        case (cur_mode)
            bp24_pkg::MODE_PALETTE:
            begin
                c = colour_table[data];
                step_bytes.push_back('{c[7:0], 1'b0, 1'b0});
                step_bytes.push_back('{c[15:8], 1'b0, 1'b0});
                step_bytes.push_back('{c[23:16], 1'b0, 1'b0});
                close_pixel(1'b0);
            end
            bp24_pkg::MODE_PASS:
            begin
                step_bytes.push_back('{data, 1'b0, 1'b0});
                if (pix_pos >= 2)
                begin
                    pix_pos = 2'd0;
                    close_pixel(1'b1);
                end
                else
                    pix_pos++;
            end
            default:
            begin
                if (pix_pos < 3)
                begin
                    bgra_gather[8 * pix_pos +: 8] = data;
                    pix_pos++;
                end
                else
                begin
                    a = int'(data);
                    for (int k = 0; k < 3; k++)
                    begin
                        mix = ((full - a) * int'(bg_color[8 * k +: 8])
                               + a * int'(bgra_gather[8 * k +: 8])) / full;
                        step_bytes.push_back('{mix[7:0], 1'b0, 1'b0});
                    end
                    pix_pos = 2'd0;
                    close_pixel(1'b0);
                end
            end
        endcase
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].last = 1'b1;
        foreach (step_bytes[i])
            expected_bytes.push_back(step_bytes[i]);
    endfunction

    // never point a palette lookup at an entry that was not written
    function automatic logic [7:0] next_data_byte();
        int pick;
        if (cur_mode == bp24_pkg::MODE_PALETTE && pad_left == 0)
            return filled_list[$urandom_range(0, filled_list.size() - 1)];
        if (cur_mode == bp24_pkg::MODE_BLEND && pad_left == 0 && pix_pos == 3)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                return 8'h00;
            if (pick == 1)
                return AlphaMax;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word(bp24_pkg::cmd_t cmd, logic [7:0] data, logic [7:0] index,
                             logic [ColorW-1:0] colour);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_in.valid       <= 1'b1;
        pixel_in.command     <= cmd;
        pixel_in.data_byte   <= data;
        pixel_in.table_index <= index;
        pixel_in.table_color <= colour;
        do
            @(posedge clk);
        while (!pixel_in.ready);
        predict_bgr_bytes(cmd, data, index, colour);
        words_sent++;
    endtask

    task automatic send_pixel(logic [7:0] data);
        send_word(bp24_pkg::CMD_PIXEL, data, 8'($urandom_range(0, 255)), ColorW'($urandom));
    endtask

    task automatic send_entry(logic [7:0] index, logic [ColorW-1:0] colour);
        send_word(bp24_pkg::CMD_PALETTE, 8'($urandom_range(0, 255)), index, colour);
    endtask

    task automatic write_reg(bp24_pkg::reg_idx_t idx, logic [CfgDataW-1:0] value);
        @(negedge clk);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.reg_data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            bp24_pkg::REG_MODE:  cur_mode  = bp24_pkg::mode_t'(value[1:0]);
            bp24_pkg::REG_WIDTH: row_width = value[WidthW-1:0];
            bp24_pkg::REG_BG:    bg_color  = value[ColorW-1:0];
            default:             ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // drop valid, drain the output, then let a silent word finish inside the block
    task automatic wait_idle();
        @(negedge clk);
        pixel_in.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic test_palette_defaults();
        send_entry(8'h00, 24'h000000);
        send_entry(8'hff, 24'hffffff);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'h00);
        send_pixel(next_data_byte());
        send_pixel(8'hff);
    endtask

    task automatic test_pass_through();
        wait_idle();
        write_reg(bp24_pkg::REG_WIDTH, 24'd0);
        write_reg(bp24_pkg::REG_MODE, CfgDataW'(bp24_pkg::MODE_PASS));
        repeat (7) send_pixel(8'($urandom_range(0, 255)));
    endtask

    task automatic test_blend();
        wait_idle();
        write_reg(bp24_pkg::REG_MODE, CfgDataW'(bp24_pkg::MODE_BLEND));
        write_reg(bp24_pkg::REG_WIDTH, 24'd1);
        write_reg(bp24_pkg::REG_BG, 24'h000000);
        send_pixel(8'hff);
        send_pixel(8'h80);
        send_pixel(8'h01);
        send_pixel(8'h00);
        send_pixel(8'h12);
        send_pixel(8'h34);
        send_pixel(8'h56);
        send_pixel(AlphaMax);
    endtask

    task automatic test_mode_switch_mid_pixel();
        wait_idle();
        send_pixel(8'($urandom_range(0, 255)));
        send_pixel(8'($urandom_range(0, 255)));
        wait_idle();
        write_reg(bp24_pkg::REG_MODE, CfgDataW'(bp24_pkg::MODE_PASS));
        send_pixel(8'($urandom_range(0, 255)));
        send_pixel(8'($urandom_range(0, 255)));
    endtask

    task automatic test_width_clamp_and_lower();
        wait_idle();
        write_reg(bp24_pkg::REG_MODE, CfgDataW'(bp24_pkg::MODE_PALETTE));
        write_reg(bp24_pkg::REG_WIDTH, 24'h1fff);
        send_pixel(next_data_byte());
        send_pixel(next_data_byte());
        wait_idle();
        write_reg(bp24_pkg::REG_WIDTH, 24'd2);
        send_pixel(next_data_byte());
    endtask

    task automatic test_unused_mode();
        wait_idle();
        write_reg(bp24_pkg::REG_MODE, CfgDataW'(bp24_pkg::MODE_UNUSED));
        send_pixel(8'($urandom_range(0, 255)));
        send_entry(8'($urandom_range(0, 255)), ColorW'($urandom));
        send_pixel(8'($urandom_range(0, 255)));
        wait_idle();
        write_reg(bp24_pkg::REG_NONE, 24'habcdef);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(bp24_pkg::REG_MODE, CfgDataW'(bp24_pkg::MODE_PALETTE));
        write_reg(bp24_pkg::REG_WIDTH, 24'd3);
        in_gap_max = 0;
        hold_left  = LongHold;
        repeat (15) send_pixel(next_data_byte());
        wait_idle();
    endtask

    task automatic test_random_phases();
        int phase_len;
        int pick;
        logic [CfgDataW-1:0] w;
        logic [CfgDataW-1:0] bg;
        while (random_items < RandomTarget)
        begin
            wait_idle();
            pick = $urandom_range(0, 3);
            in_gap_max  = pick[0] ? 11 : 0;
            out_gap_max = pick[1] ? 11 : 0;
            case ($urandom_range(0, 11))
                0:       w = 24'd0;
                1:       w = CfgDataW'(MaxWidth);
                2:       w = 24'h1fff;
                default: w = CfgDataW'($urandom_range(1, 7));
            endcase
            case ($urandom_range(0, 5))
                0:       bg = 24'h000000;
                1:       bg = 24'hffffff;
                default: bg = CfgDataW'($urandom);
            endcase
            write_reg(bp24_pkg::REG_MODE,
                      CfgDataW'($urandom_range(bp24_pkg::MODE_PALETTE, bp24_pkg::MODE_BLEND)));
            write_reg(bp24_pkg::REG_WIDTH, w);
            write_reg(bp24_pkg::REG_BG, bg);
            phase_len = $urandom_range(8, 20);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_entry(8'($urandom_range(0, 255)), ColorW'($urandom));
                else
                    send_pixel(next_data_byte());
                random_items++;
            end
        end
    endtask

    always @(posedge clk)
    begin : check_bytes
        bgr_word_t want;
        if (rst_n && byte_out.valid && byte_out.ready)
        begin
            bytes_checked++;
            out_gap = $urandom_range(0, out_gap_max);
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output word, out_byte %0h", byte_out.out_byte);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (byte_out.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte,
                           byte_out.out_byte);
                    mismatches++;
                end
                if (byte_out.row_end !== want.row_end)
                begin
                    $error("row_end: expected %0b, actual %0b", want.row_end,
                           byte_out.row_end);
                    mismatches++;
                end
                if (byte_out.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, byte_out.last);
                    mismatches++;
                end
            end
        end
    end

    // hold off the output, either for a long stretch or for the per-word gap
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            byte_out.ready <= 1'b0;
            hold_left--;
        end
        else if (out_gap > 0)
        begin
            byte_out.ready <= 1'b0;
            out_gap--;
        end
        else
            byte_out.ready <= 1'b1;
    end

    initial
    begin
        rst_n                = 1'b0;
        pixel_in.valid       = 1'b0;
        pixel_in.command     = bp24_pkg::CMD_PIXEL;
        pixel_in.data_byte   = 8'h00;
        pixel_in.table_index = 8'h00;
        pixel_in.table_color = '0;
        byte_out.ready       = 1'b0;
        cfg.valid            = 1'b0;
        cfg.reg_index        = bp24_pkg::REG_MODE;
        cfg.reg_data         = '0;
        cur_mode    = bp24_pkg::MODE_PALETTE;
        row_width   = WidthW'(1);
        bg_color    = 24'hffffff;
        pix_pos     = 2'd0;
        col_count   = 0;
        pad_left    = 2'd0;
        bgra_gather = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        in_gap_max  = 11;
        out_gap_max = 11;
        test_palette_defaults();
        test_pass_through();
        test_blend();
        test_mode_switch_mid_pixel();
        test_width_clamp_and_lower();
        test_unused_mode();
        test_backpressure();
        test_random_phases();
        wait_idle();
        $display("Sent %0d input words (%0d in random phases), checked %0d output bytes",
                 words_sent, random_items, bytes_checked);
        $display("Covered palette, pass-through, blend and unused modes, padding and stalls");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(LimitCycles * 2 * HalfPeriod);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
